>>> rtl/core/bpa_pkg.sv
// Shared types and constants for the bitmap page allocator.
// Depends on nothing; bpa_datapath, bpa_controller and bitmap_page_allocator use it.
package bpa_pkg;

    localparam int PAGES_DEFAULT = 1024;
    localparam int WORD_W = 32;
    localparam int OFF_W = 5;
    localparam int CNT_W = 11;
    localparam int START_W = 10;
    localparam int STATUS_W = 2;

    localparam logic [CNT_W-1:0] USED_MAX = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] BOUNDARY_RESET = 11'd512;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK         = 2'd0,
        STATUS_FALLBACK   = 2'd1,
        STATUS_NO_RUN     = 2'd2,
        STATUS_NO_SYS_RUN = 2'd3
    } status_code_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_MARK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic         init_step;
        logic         load_req;
        logic         scan_start;
        logic         scan_from_zero;
        logic         scan_run;
        logic         mark_start;
        logic         mark_run;
        logic         used_update;
        logic         set_result;
        status_code_t result_code;
        logic         result_take_first;
        logic         out_load;
    } cmd_t;

    typedef struct packed {
        logic init_done;
        logic is_free;
        logic count_zero;
        logic free_empty;
        logic sys_req;
        logic boundary_in_map;
        logic scan_hit;
        logic scan_end;
        logic sys_reject;
        logic mark_done;
    } dp_status_t;

endpackage

>>> rtl/core/bpa_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/bpa_datapath.sv
// Datapath of the page allocator: request registers, page map memory, run search
// and run marking. Depends on bpa_pkg and bpa_ram; driven by bpa_controller.
module bpa_datapath #(
    parameter int PAGES = bpa_pkg::PAGES_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  bpa_pkg::cmd_t                   cmd,
    output bpa_pkg::dp_status_t             sts,
    input  logic                            cfg_we,
    input  logic [bpa_pkg::CNT_W-1:0]       cfg_wdata,
    input  logic                            action,
    input  logic [bpa_pkg::CNT_W-1:0]       run_pages,
    input  logic                            system_request,
    input  logic [bpa_pkg::START_W-1:0]     start_page,
    output logic [bpa_pkg::STATUS_W-1:0]    status,
    output logic [bpa_pkg::START_W-1:0]     first_page,
    output logic [bpa_pkg::CNT_W-1:0]       pages_in_use
);

    localparam int WORD_W = bpa_pkg::WORD_W;
    localparam int OFF_W = bpa_pkg::OFF_W;
    localparam int CNT_W = bpa_pkg::CNT_W;
    localparam int START_W = bpa_pkg::START_W;
    localparam int WORDS = (PAGES + WORD_W - 1) / WORD_W;
    localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PW = $clog2(PAGES) + 1;
    localparam int LW = ((PW > CNT_W) ? PW : CNT_W) + 1;
    localparam logic [LW-1:0] PAGES_L = LW'(PAGES);
    localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);
    localparam logic [WORD_W-1:0] ONES = {WORD_W{1'b1}};

    logic                         action_reg;
    logic [CNT_W-1:0]             count_reg;
    logic                         sys_reg;
    logic [START_W-1:0]           start_reg;
    logic [CNT_W-1:0]             boundary_reg;
    logic [CNT_W-1:0]             used_reg;
    logic [CNT_W-1:0]             used_next;
    logic [AW-1:0]                init_addr_reg;

    logic [AW-1:0]                scan_addr_reg;
    logic                         scan_issue_done_reg;
    logic                         scan_issue_first_reg;
    logic                         scan_pend_reg;
    logic                         scan_pend_first_reg;
    logic [AW-1:0]                scan_pend_addr_reg;
    logic [OFF_W-1:0]             scan_off_reg;
    logic [CNT_W-1:0]             scan_carry_reg;
    logic                         scan_hit_reg;
    logic                         scan_end_reg;
    logic [LW-1:0]                at_reg;

    logic [AW-1:0]                mark_addr_reg;
    logic                         mark_issue_done_reg;
    logic                         mark_pend_reg;
    logic [AW-1:0]                mark_pend_addr_reg;
    logic [AW-1:0]                mark_first_word_reg;
    logic [AW-1:0]                mark_last_word_reg;
    logic [OFF_W-1:0]             mark_lo_off_reg;
    logic [OFF_W-1:0]             mark_hi_off_reg;
    logic                         mark_val_reg;

    bpa_pkg::status_code_t        res_status_reg;
    logic [START_W-1:0]           res_first_reg;
    bpa_pkg::status_code_t        out_status_reg;
    logic [START_W-1:0]           out_first_reg;
    logic [CNT_W-1:0]             out_used_reg;

    logic [LW-1:0]                start_l;
    logic [LW-1:0]                count_l;
    logic [LW-1:0]                boundary_l;
    logic [LW-1:0]                free_rem;
    logic [LW-1:0]                free_len_l;
    logic [CNT_W-1:0]             free_len;
    logic [LW-1:0]                from_l;
    logic [LW-1:0]                lo_l;
    logic [LW-1:0]                end_l;
    logic [CNT_W:0]               used_sum;

    logic [WORD_W-1:0]            eff_word;
    logic [CNT_W:0]               run_len [WORD_W];
    logic [WORD_W-1:0]            hit_vec;
    logic [OFF_W-1:0]             hit_pos;
    logic                         hit_any;
    logic [LW-1:0]                at_comb;
    logic [CNT_W-1:0]             carry_next;
    logic                         scan_proc;

    logic [WORD_W-1:0]            mark_mask;
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [WORD_W-1:0]            ram_wdata;
    logic [AW-1:0]                ram_raddr;
    logic [WORD_W-1:0]            ram_rdata;

    bpa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS),
        .AW    (AW)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign start_l = LW'(start_reg);
    assign count_l = LW'(count_reg);
    assign boundary_l = LW'(boundary_reg);
    assign free_rem = PAGES_L - start_l;

    always_comb
    begin
        if (start_l < PAGES_L)
        begin
            free_len_l = (count_l < free_rem) ? count_l : free_rem;
        end
        else
        begin
            free_len_l = '0;
        end
    end

    assign free_len = free_len_l[CNT_W-1:0];
    assign from_l = cmd.scan_from_zero ? '0 : boundary_l;
    assign lo_l = action_reg ? start_l : at_reg;
    assign end_l = lo_l + (action_reg ? free_len_l : count_l) - LW'(1);

    // Pages below the scan origin in the first word count as used.
    assign eff_word = ram_rdata | (scan_pend_first_reg ? ~(ONES << scan_off_reg) : '0);

    always_comb
    begin
        logic             any_used;
        logic [OFF_W-1:0] last_used;
        for (int j = 0; j < WORD_W; j++)
        begin
            any_used = 1'b0;
            last_used = '0;
            for (int k = 0; k <= j; k++)
            begin
                if (eff_word[k])
                begin
                    any_used = 1'b1;
                    last_used = OFF_W'(k);
                end
            end
            if (any_used)
            begin
                run_len[j] = (CNT_W + 1)'(j) - (CNT_W + 1)'(last_used);
            end
            else
            begin
                run_len[j] = {1'b0, scan_carry_reg} + (CNT_W + 1)'(j + 1);
            end
            hit_vec[j] = (run_len[j] >= {1'b0, count_reg});
        end
    end

    always_comb
    begin
        hit_pos = '0;
        for (int j = WORD_W - 1; j >= 0; j--)
        begin
            if (hit_vec[j])
            begin
                hit_pos = OFF_W'(j);
            end
        end
    end

    assign hit_any = |hit_vec;
    assign at_comb = LW'({scan_pend_addr_reg, {OFF_W{1'b0}}}) + LW'(hit_pos) + LW'(1) - count_l;
    assign carry_next = run_len[WORD_W-1][CNT_W] ? bpa_pkg::USED_MAX
                                                 : run_len[WORD_W-1][CNT_W-1:0];
    assign scan_proc = scan_pend_reg && !scan_hit_reg && !scan_end_reg;

    always_comb
    begin
        mark_mask = ONES;
        if (mark_pend_addr_reg == mark_first_word_reg)
        begin
            mark_mask = mark_mask & (ONES << mark_lo_off_reg);
        end
        if (mark_pend_addr_reg == mark_last_word_reg)
        begin
            mark_mask = mark_mask & (ONES >> (OFF_W'(WORD_W - 1) - mark_hi_off_reg));
        end
    end

    always_comb
    begin
        if (cmd.init_step)
        begin
            ram_we = 1'b1;
            ram_waddr = init_addr_reg;
            ram_wdata = ONES;
        end
        else
        begin
            ram_we = mark_pend_reg;
            ram_waddr = mark_pend_addr_reg;
            ram_wdata = mark_val_reg ? (ram_rdata | mark_mask) : (ram_rdata & ~mark_mask);
        end
    end

    assign ram_raddr = cmd.mark_run ? mark_addr_reg : scan_addr_reg;

    assign used_sum = {1'b0, used_reg} + {1'b0, count_reg};

    always_comb
    begin
        if (action_reg)
        begin
            used_next = (used_reg > free_len) ? (used_reg - free_len) : '0;
        end
        else
        begin
            used_next = used_sum[CNT_W] ? bpa_pkg::USED_MAX : used_sum[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boundary_reg <= bpa_pkg::BOUNDARY_RESET;
            used_reg <= '0;
            init_addr_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                boundary_reg <= cfg_wdata;
            end
            if (cmd.used_update)
            begin
                used_reg <= used_next;
            end
            if (cmd.init_step && (init_addr_reg != LAST_WORD))
            begin
                init_addr_reg <= init_addr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            action_reg <= action;
            count_reg <= run_pages;
            sys_reg <= system_request;
            start_reg <= start_page;
        end
        if (cmd.set_result)
        begin
            res_status_reg <= cmd.result_code;
            res_first_reg <= cmd.result_take_first ? at_reg[START_W-1:0] : '0;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_first_reg <= res_first_reg;
            out_used_reg <= used_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_issue_done_reg <= 1'b1;
            scan_issue_first_reg <= 1'b0;
            scan_pend_reg <= 1'b0;
            scan_hit_reg <= 1'b0;
            scan_end_reg <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            scan_issue_done_reg <= 1'b0;
            scan_issue_first_reg <= 1'b1;
            scan_pend_reg <= 1'b0;
            scan_hit_reg <= 1'b0;
            scan_end_reg <= 1'b0;
        end
        else if (cmd.scan_run)
        begin
            scan_pend_reg <= !scan_issue_done_reg;
            if (!scan_issue_done_reg)
            begin
                scan_issue_first_reg <= 1'b0;
                if (scan_addr_reg == LAST_WORD)
                begin
                    scan_issue_done_reg <= 1'b1;
                end
            end
            if (scan_proc)
            begin
                if (hit_any)
                begin
                    scan_hit_reg <= 1'b1;
                end
                else if (scan_pend_addr_reg == LAST_WORD)
                begin
                    scan_end_reg <= 1'b1;
                end
            end
        end
        else
        begin
            scan_pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            scan_addr_reg <= from_l[OFF_W +: AW];
            scan_off_reg <= from_l[OFF_W-1:0];
            scan_carry_reg <= '0;
        end
        else if (cmd.scan_run)
        begin
            if (!scan_issue_done_reg)
            begin
                scan_pend_addr_reg <= scan_addr_reg;
                scan_pend_first_reg <= scan_issue_first_reg;
                if (scan_addr_reg != LAST_WORD)
                begin
                    scan_addr_reg <= scan_addr_reg + AW'(1);
                end
            end
            if (scan_proc)
            begin
                if (hit_any)
                begin
                    at_reg <= at_comb;
                end
                else
                begin
                    scan_carry_reg <= carry_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_issue_done_reg <= 1'b1;
            mark_pend_reg <= 1'b0;
        end
        else if (cmd.mark_start)
        begin
            mark_issue_done_reg <= 1'b0;
            mark_pend_reg <= 1'b0;
        end
        else if (cmd.mark_run)
        begin
            mark_pend_reg <= !mark_issue_done_reg;
            if (!mark_issue_done_reg && (mark_addr_reg == mark_last_word_reg))
            begin
                mark_issue_done_reg <= 1'b1;
            end
        end
        else
        begin
            mark_pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mark_start)
        begin
            mark_addr_reg <= lo_l[OFF_W +: AW];
            mark_first_word_reg <= lo_l[OFF_W +: AW];
            mark_last_word_reg <= end_l[OFF_W +: AW];
            mark_lo_off_reg <= lo_l[OFF_W-1:0];
            mark_hi_off_reg <= end_l[OFF_W-1:0];
            mark_val_reg <= !action_reg;
        end
        else if (cmd.mark_run && !mark_issue_done_reg)
        begin
            mark_pend_addr_reg <= mark_addr_reg;
            if (mark_addr_reg != mark_last_word_reg)
            begin
                mark_addr_reg <= mark_addr_reg + AW'(1);
            end
        end
    end

    assign sts.init_done = (init_addr_reg == LAST_WORD);
    assign sts.is_free = action_reg;
    assign sts.count_zero = (count_reg == '0);
    assign sts.free_empty = (free_len == '0);
    assign sts.sys_req = sys_reg;
    assign sts.boundary_in_map = (boundary_l < PAGES_L);
    assign sts.scan_hit = scan_hit_reg;
    assign sts.scan_end = scan_end_reg;
    assign sts.sys_reject = ((at_reg + count_l) >= boundary_l);
    assign sts.mark_done = mark_pend_reg && (mark_pend_addr_reg == mark_last_word_reg);

    assign status = out_status_reg;
    assign first_page = out_first_reg;
    assign pages_in_use = out_used_reg;

endmodule

>>> rtl/core/bpa_controller.sv
// Sequencer of the page allocator: request handshake, scan and marking steps,
// result hand-off. Depends on bpa_pkg; commands bpa_datapath.
module bpa_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  bpa_pkg::dp_status_t sts,
    output bpa_pkg::cmd_t       cmd
);

    bpa_pkg::state_t state_reg;
    bpa_pkg::state_t state_next;
    logic            fallback_reg;
    logic            fallback_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bpa_pkg::ST_INIT;
            fallback_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fallback_reg <= fallback_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        fallback_next = fallback_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready = 1'b0;
        cmd = '0;
        cmd.result_code = bpa_pkg::STATUS_OK;
        case (state_reg)
            bpa_pkg::ST_INIT:
            begin
                cmd.init_step = 1'b1;
                if (sts.init_done)
                begin
                    state_next = bpa_pkg::ST_IDLE;
                end
            end
            bpa_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next = bpa_pkg::ST_DECIDE;
                end
            end
            bpa_pkg::ST_DECIDE:
            begin
                fallback_next = 1'b0;
                if (sts.is_free)
                begin
                    cmd.set_result = 1'b1;
                    cmd.result_code = bpa_pkg::STATUS_OK;
                    if (sts.free_empty)
                    begin
                        state_next = bpa_pkg::ST_DONE;
                    end
                    else
                    begin
                        cmd.mark_start = 1'b1;
                        state_next = bpa_pkg::ST_MARK;
                    end
                end
                else if (sts.count_zero)
                begin
                    cmd.set_result = 1'b1;
                    cmd.result_code = bpa_pkg::STATUS_NO_RUN;
                    state_next = bpa_pkg::ST_DONE;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    cmd.scan_from_zero = sts.sys_req || !sts.boundary_in_map;
                    fallback_next = !sts.sys_req && !sts.boundary_in_map;
                    state_next = bpa_pkg::ST_SCAN;
                end
            end
            bpa_pkg::ST_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (sts.scan_hit)
                begin
                    cmd.set_result = 1'b1;
                    if (sts.sys_req && sts.sys_reject)
                    begin
                        cmd.result_code = bpa_pkg::STATUS_NO_SYS_RUN;
                        state_next = bpa_pkg::ST_DONE;
                    end
                    else
                    begin
                        cmd.result_code = fallback_reg ? bpa_pkg::STATUS_FALLBACK
                                                       : bpa_pkg::STATUS_OK;
                        cmd.result_take_first = 1'b1;
                        cmd.mark_start = 1'b1;
                        state_next = bpa_pkg::ST_MARK;
                    end
                end
                else if (sts.scan_end)
                begin
                    if (!sts.sys_req && !fallback_reg)
                    begin
                        cmd.scan_start = 1'b1;
                        cmd.scan_from_zero = 1'b1;
                        fallback_next = 1'b1;
                    end
                    else
                    begin
                        cmd.set_result = 1'b1;
                        cmd.result_code = bpa_pkg::STATUS_NO_RUN;
                        state_next = bpa_pkg::ST_DONE;
                    end
                end
            end
            bpa_pkg::ST_MARK:
            begin
                cmd.mark_run = 1'b1;
                if (sts.mark_done)
                begin
                    cmd.used_update = 1'b1;
                    state_next = bpa_pkg::ST_DONE;
                end
            end
            bpa_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = bpa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bpa_pkg::ST_INIT;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

>>> rtl/core/bitmap_page_allocator.sv
// Top level of the bitmap first-fit page allocator.
// Depends on bpa_pkg, bpa_controller, bpa_datapath (which holds bpa_ram).
//
//   Channel  Handshake              Fields
//   in       in_valid / in_ready    action, run_pages, system_request, start_page
//   out      out_valid / out_ready  status, first_page, pages_in_use
//   cfg      cfg_we                 cfg_wdata (system_boundary_page)
//
// One request is in work at a time: it is taken in IDLE, decoded in DECIDE,
// and its result is loaded in DONE. A scan reads one 32-page word a cycle;
// a normal request that misses above the boundary scans again from page 0.
// Marking reads and rewrites each map word that the run touches. After reset
// every map word is set to all used before in_ready rises. A result waits in
// the output register until out_ready takes it.
module bitmap_page_allocator #(
    parameter int PAGES = bpa_pkg::PAGES_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [bpa_pkg::CNT_W-1:0]    cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         action,
    input  logic [bpa_pkg::CNT_W-1:0]    run_pages,
    input  logic                         system_request,
    input  logic [bpa_pkg::START_W-1:0]  start_page,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [bpa_pkg::STATUS_W-1:0] status,
    output logic [bpa_pkg::START_W-1:0]  first_page,
    output logic [bpa_pkg::CNT_W-1:0]    pages_in_use
);

    bpa_pkg::cmd_t       cmd;
    bpa_pkg::dp_status_t sts;

    bpa_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bpa_datapath #(
        .PAGES (PAGES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .action         (action),
        .run_pages      (run_pages),
        .system_request (system_request),
        .start_page     (start_page),
        .status         (status),
        .first_page     (first_page),
        .pages_in_use   (pages_in_use)
    );

endmodule

>>> sim/bitmap_page_allocator_test.sv
// Self-checking testbench for bitmap_page_allocator: a scoreboard class predicts each
// request's result from its own copy of the page map, and tasks drive the request valid/ready handshake.
// Depends on bpa_pkg and the RTL under rtl/core.
module bitmap_page_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bpa_pkg::*;

    localparam int MAP_PAGES = PAGES_DEFAULT;
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE = 1'b1;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 500;
    localparam int PHASE_ITEMS = 185;

    class alloc_scoreboard;
        typedef struct packed {
            logic [STATUS_W-1:0] status;
            logic [START_W-1:0]  first_page;
            logic [CNT_W-1:0]    pages_in_use;
        } alloc_result_t;

        bit [MAP_PAGES-1:0] map_bits;
        int                 used_count;
        int                 boundary;
        alloc_result_t      expected_q[$];
        int                 error_count;

        function new();
            map_bits = '1;
            used_count = 0;
            boundary = BOUNDARY_RESET;
            error_count = 0;
        endfunction

        function void set_boundary(logic [CNT_W-1:0] value);
            boundary = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function int find_free_run(int from, int len);
            int run_start;
            int run_len;
            run_start = from;
            run_len = 0;
            for (int i = from; i < MAP_PAGES; i++)
            begin
                if (map_bits[i])
                begin
                    run_start = i + 1;
                    run_len = 0;
                end
                else
                begin
                    run_len++;
                    if (run_len >= len)
                        return run_start;
                end
            end
            return -1;
        endfunction

        function void mark_pages(int first, int len, bit value);
            for (int i = first; i < first + len && i < MAP_PAGES; i++)
                map_bits[i] = value;
        endfunction

        function void note_request(logic act, logic [CNT_W-1:0] cnt, logic sys,
                                   logic [START_W-1:0] start);
            int           n;
            int           at;
            int           len;
            status_code_t code;
            alloc_result_t r;
            code = STATUS_OK;
            at = -1;
            len = cnt;
            if (act == ACT_FREE)
            begin
                n = MAP_PAGES - int'(start);
                if (len < n)
                    n = len;
                mark_pages(start, n, 1'b0);
                used_count = (used_count > n) ? used_count - n : 0;
            end
            else if (len == 0)
                code = STATUS_NO_RUN;
            else if (sys)
            begin
                at = find_free_run(0, len);
                if (at < 0)
                    code = STATUS_NO_RUN;
                else if (at + len >= boundary)
                begin
                    code = STATUS_NO_SYS_RUN;
                    at = -1;
                end
            end
            else
            begin
                at = find_free_run(boundary, len);
                if (at < 0)
                begin
                    at = find_free_run(0, len);
                    code = (at >= 0) ? STATUS_FALLBACK : STATUS_NO_RUN;
                end
            end
            if (at >= 0)
            begin
                mark_pages(at, len, 1'b1);
                used_count += len;
                if (used_count > int'(USED_MAX))
                    used_count = USED_MAX;
            end
            r.status = code;
            r.first_page = (at >= 0) ? START_W'(at) : '0;
            r.pages_in_use = CNT_W'(used_count);
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic [START_W-1:0] fp,
                                   logic [CNT_W-1:0] piu);
            alloc_result_t r;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result status %0d first_page %0d pages_in_use %0d",
                         $time, st, fp, piu);
                error_count++;
                return;
            end
            r = expected_q.pop_front();
            if (st !== r.status)
            begin
                $display("%0t: status expected %0d, got %0d", $time, r.status, st);
                error_count++;
            end
            if (fp !== r.first_page)
            begin
                $display("%0t: first_page expected %0d, got %0d", $time, r.first_page, fp);
                error_count++;
            end
            if (piu !== r.pages_in_use)
            begin
                $display("%0t: pages_in_use expected %0d, got %0d", $time, r.pages_in_use, piu);
                error_count++;
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [CNT_W-1:0]    cfg_wdata = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic                action = 1'b0;
    logic [CNT_W-1:0]    run_pages = '0;
    logic                system_request = 1'b0;
    logic [START_W-1:0]  start_page = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [START_W-1:0]  first_page;
    logic [CNT_W-1:0]    pages_in_use;

    alloc_scoreboard sb;
    int              idle_pct = 0;
    int              stall_pct = 0;
    bit              hold_off_req = 1'b0;
    int              quiet_cycles = 0;

    bitmap_page_allocator u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .run_pages      (run_pages),
        .system_request (system_request),
        .start_page     (start_page),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .first_page     (first_page),
        .pages_in_use   (pages_in_use)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (in_valid && in_ready)
                sb.note_request(action, run_pages, system_request, start_page);
            if (out_valid && out_ready)
                sb.check_result(status, first_page, pages_in_use);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1)
                begin
                    @(posedge clk);
                    out_ready <= 1'b0;
                end
            end
            else
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("bitmap_page_allocator: mismatch");
        $finish;
    end

    task automatic send_request(input logic act, input logic [CNT_W-1:0] cnt, input logic sys,
                                input logic [START_W-1:0] start);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        run_pages <= cnt;
        system_request <= sys;
        start_page <= start;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_boundary(input logic [CNT_W-1:0] value);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_boundary(value);
    endtask

    task automatic send_random();
        int   pick;
        int   cnt;
        int   start;
        logic act;
        act = ($urandom_range(0, 99) < 45) ? ACT_FREE : ACT_ALLOC;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            cnt = $urandom_range(1, 16);
        else if (pick < 87)
            cnt = $urandom_range(17, 128);
        else if (pick < 96)
            cnt = $urandom_range(129, 1024);
        else if (pick < 98)
            cnt = $urandom_range(1025, 2047);
        else
            cnt = 0;
        start = $urandom_range(0, MAP_PAGES - 1);
        if (act == ACT_FREE && $urandom_range(0, 39) == 0)
        begin
            cnt = MAP_PAGES;
            start = 0;
        end
        send_request(act, CNT_W'(cnt), 1'($urandom_range(0, 1)), START_W'(start));
    endtask

    initial
    begin
        int phase_boundary[8];
        sb = new();
        phase_boundary = '{0, 1024, 2047, 1, 300, 1023, 768, 0};
        phase_boundary[7] = $urandom_range(2, 1022);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests run with the boundary at its reset value.
        send_request(ACT_ALLOC, 11'd1, 1'b0, 10'd0);
        send_request(ACT_ALLOC, 11'd0, 1'b0, 10'd0);
        send_request(ACT_ALLOC, 11'd1, 1'b1, 10'd0);
        send_request(ACT_FREE, 11'd2047, 1'b0, 10'd1023);
        send_request(ACT_ALLOC, 11'd1, 1'b0, 10'd0);
        send_request(ACT_FREE, 11'd2047, 1'b1, 10'd0);
        send_request(ACT_FREE, 11'd0, 1'b0, 10'd0);
        send_request(ACT_ALLOC, 11'd2047, 1'b0, 10'd0);
        send_request(ACT_ALLOC, 11'd1024, 1'b0, 10'd1023);
        send_request(ACT_FREE, 11'd1024, 1'b0, 10'd0);
        send_request(ACT_ALLOC, 11'd100, 1'b1, 10'd0);
        send_request(ACT_ALLOC, 11'd500, 1'b1, 10'd0);
        send_request(ACT_ALLOC, 11'd411, 1'b1, 10'd0);
        send_request(ACT_ALLOC, 11'd1, 1'b1, 10'd0);
        send_request(ACT_ALLOC, 11'd512, 1'b0, 10'd0);
        send_request(ACT_ALLOC, 11'd1, 1'b0, 10'd0);
        send_request(ACT_FREE, 11'd16, 1'b0, 10'd256);
        send_request(ACT_FREE, 11'd16, 1'b0, 10'd256);
        send_request(ACT_ALLOC, 11'd8, 1'b0, 10'd0);
        send_request(ACT_ALLOC, 11'd0, 1'b1, 10'd0);
        send_request(ACT_FREE, 11'd1, 1'b0, 10'd1023);
        send_request(ACT_ALLOC, 11'd1, 1'b0, 10'd0);
        send_request(ACT_FREE, 11'd1024, 1'b0, 10'd0);

        for (int p = 0; p < 8; p++)
        begin
            write_boundary(CNT_W'(phase_boundary[p]));
            case (p % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 67;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 67;
                end
                default:
                begin
                    idle_pct = 17;
                    stall_pct = 17;
                end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ((p == 0 || p == 4) && i == 60)
                    hold_off_req = 1'b1;
                if (p == 1 && i == 90)
                    wait_drained();
                send_random();
            end
        end

        wait_drained();
        repeat (200) @(posedge clk);
        if (sb.error_count == 0 && sb.pending() == 0)
            $display("bitmap_page_allocator: match");
        else
            $display("bitmap_page_allocator: mismatch");
        $finish;
    end
endmodule
